FILE: rtl/core/dhmr_pkg.sv
package dhmr_pkg;

  // Fixed field widths
  localparam int unsigned HeightW = 11;
  localparam int unsigned AreaW   = 21;
  localparam logic [AreaW-1:0] AreaMax = {AreaW{1'b1}};

  // Command queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // Stack engine status toward the back controller
  typedef struct packed {
    logic             idle;
    logic             hold;
    logic [AreaW-1:0] best;
  } eng_status_t;

endpackage

FILE: rtl/core/dual_histogram_max_rectangle.sv
// Largest rectangle over two histograms, one column per transaction.
// Input: drive height_first_i, height_second_i and last_column_i with start;
// the transaction is taken at a rising edge where start is high and busy is
// low. Columns are numbered from 0 per query; the column at MAX_COLUMNS-1
// ends the query even without last_column_i.
// Output: on the last column of a query, max_area_o is shown for one cycle
// with valid_o high; there is no back-pressure on this side.
// A front stage queues up to two columns. Each histogram has its own stack
// engine, which pops every taller bar before pushing the column; both engines
// run in step, since a column is issued only when both are idle. On the last
// column each engine flushes its stacked bars and drains the multiplier, then
// the larger of the two best areas is registered to max_area_o with valid_o.
// Reset clears the column count, both stacks and both best areas; stack RAM
// contents need no clearing since only entries pushed in this query are read.
module dual_histogram_max_rectangle #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_HEIGHT  = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [dhmr_pkg::HeightW-1:0]  height_first_i,
  input  logic [dhmr_pkg::HeightW-1:0]  height_second_i,
  input  logic                          last_column_i,
  output logic                          valid_o,
  output logic [dhmr_pkg::AreaW-1:0]    max_area_o
);

  import dhmr_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_COLUMNS);

  logic               q_valid, q_last, issue, both_hold;
  logic [HeightW-1:0] q_h_first, q_h_second;
  logic [ColW-1:0]    q_col;
  eng_status_t        st_first, st_second;
  logic               valid_q;
  logic [AreaW-1:0]   max_area_q;

  dhmr_front #(
    .MaxColumns(MAX_COLUMNS),
    .MaxHeight (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .height_first_i (height_first_i),
    .height_second_i(height_second_i),
    .last_column_i  (last_column_i),
    .q_valid_o      (q_valid),
    .q_h_first_o    (q_h_first),
    .q_h_second_o   (q_h_second),
    .q_col_o        (q_col),
    .q_last_o       (q_last),
    .q_pop_i        (issue)
  );

  // Hand a column to both engines once both are free
  assign issue     = q_valid && st_first.idle && st_second.idle;
  assign both_hold = st_first.hold && st_second.hold;

  dhmr_stack #(
    .MaxColumns(MAX_COLUMNS)
  ) u_stack_first (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(issue),
    .cmd_h_i    (q_h_first),
    .cmd_col_i  (q_col),
    .cmd_last_i (q_last),
    .ack_i      (both_hold),
    .status_o   (st_first)
  );

  dhmr_stack #(
    .MaxColumns(MAX_COLUMNS)
  ) u_stack_second (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(issue),
    .cmd_h_i    (q_h_second),
    .cmd_col_i  (q_col),
    .cmd_last_i (q_last),
    .ack_i      (both_hold),
    .status_o   (st_second)
  );

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= both_hold;
    end
  end

  always_ff @(posedge clk_i) begin
    if (both_hold) begin
      max_area_q <= (st_first.best > st_second.best) ? st_first.best : st_second.best;
    end
  end

  assign valid_o    = valid_q;
  assign max_area_o = max_area_q;

`ifndef ASSERT_OFF
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe longer than one cycle");
  a_strobe_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(both_hold))
    else $error("result without both engines done");
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    both_hold |=> st_first.idle && st_second.idle)
    else $error("engines not released after result");
`endif

endmodule

FILE: rtl/core/dhmr_ram.sv
module dhmr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/dhmr_front.sv
module dhmr_front #(
  parameter int unsigned MaxColumns = 1024,
  parameter int unsigned MaxHeight  = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [dhmr_pkg::HeightW-1:0]        height_first_i,
  input  logic [dhmr_pkg::HeightW-1:0]        height_second_i,
  input  logic                                last_column_i,
  output logic                                q_valid_o,
  output logic [dhmr_pkg::HeightW-1:0]        q_h_first_o,
  output logic [dhmr_pkg::HeightW-1:0]        q_h_second_o,
  output logic [$clog2(MaxColumns)-1:0]       q_col_o,
  output logic                                q_last_o,
  input  logic                                q_pop_i
);

  import dhmr_pkg::*;

  localparam int unsigned ColW = $clog2(MaxColumns);

  logic [ColW-1:0]    col_q, col_d;
  logic               push;
  logic               last_eff;
  logic [HeightW-1:0] h_first_c, h_second_c;

  logic [HeightW-1:0] qh1_q  [QDepth];
  logic [HeightW-1:0] qh2_q  [QDepth];
  logic [ColW-1:0]    qcol_q [QDepth];
  logic               qlast_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]     count_q, count_d;

  assign busy = (count_q == (QPtrW+1)'(QDepth));
  assign push = start && !busy;

  // Saturate heights, force the last column at capacity
  assign h_first_c  = (32'(height_first_i) > 32'(MaxHeight)) ? HeightW'(MaxHeight)
                                                              : height_first_i;
  assign h_second_c = (32'(height_second_i) > 32'(MaxHeight)) ? HeightW'(MaxHeight)
                                                               : height_second_i;
  assign last_eff   = last_column_i || (col_q == ColW'(MaxColumns - 1));

  always_comb begin
    col_d = col_q;
    if (push) begin
      col_d = last_eff ? '0 : col_q + ColW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (push && !q_pop_i) begin
      count_d = count_q + (QPtrW+1)'(1);
    end else if (!push && q_pop_i) begin
      count_d = count_q - (QPtrW+1)'(1);
    end
  end

  // Column counter and queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      col_q   <= col_d;
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (q_pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      qh1_q[wr_ptr_q]   <= h_first_c;
      qh2_q[wr_ptr_q]   <= h_second_c;
      qcol_q[wr_ptr_q]  <= col_q;
      qlast_q[wr_ptr_q] <= last_eff;
    end
  end

  assign q_valid_o    = (count_q != '0);
  assign q_h_first_o  = qh1_q[rd_ptr_q];
  assign q_h_second_o = qh2_q[rd_ptr_q];
  assign q_col_o      = qcol_q[rd_ptr_q];
  assign q_last_o     = qlast_q[rd_ptr_q];

endmodule

FILE: rtl/core/dhmr_stack.sv
module dhmr_stack #(
  parameter int unsigned MaxColumns = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  logic [dhmr_pkg::HeightW-1:0]  cmd_h_i,
  input  logic [$clog2(MaxColumns)-1:0] cmd_col_i,
  input  logic                          cmd_last_i,
  input  logic                          ack_i,
  output dhmr_pkg::eng_status_t         status_o
);

  import dhmr_pkg::*;

  localparam int unsigned ColW = $clog2(MaxColumns);
  localparam int unsigned DepW = ColW + 1;
  localparam int unsigned EntW = HeightW + ColW;
  localparam int unsigned PW   = HeightW + DepW;
  localparam int unsigned CmpW = (PW > AreaW) ? PW : AreaW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_FLUSH,
    S_DRAIN,
    S_HOLD
  } state_e;

  state_e state_q, state_d;

  // Top of stack lives in registers, entries below it in the RAM
  logic [HeightW-1:0] top_h_q, top_h_d;
  logic [ColW-1:0]    top_c_q, top_c_d;
  logic [DepW-1:0]    depth_q, depth_d;
  logic [HeightW-1:0] h_q, h_d;
  logic [ColW-1:0]    c_q, c_d;
  logic               last_q, last_d;
  logic               flush_q, flush_d;

  logic               ram_we;
  logic [ColW-1:0]    ram_waddr, ram_raddr;
  logic [EntW-1:0]    ram_wdata, ram_rdata;
  logic [HeightW-1:0] below_h;
  logic [ColW-1:0]    below_c;
  logic [DepW-1:0]    dm1, dm2, dm3;
  logic [DepW-1:0]    base, width;
  logic               more;

  logic               mul_v_q, mul_v_d;
  logic [HeightW-1:0] mul_h;
  logic [DepW-1:0]    mul_w;
  logic [PW-1:0]      mul_q;
  logic [AreaW-1:0]   area;
  logic [AreaW-1:0]   best_q, best_d;

  assign dm1 = depth_q - DepW'(1);
  assign dm2 = depth_q - DepW'(2);
  assign dm3 = depth_q - DepW'(3);
  assign below_h = ram_rdata[EntW-1:ColW];
  assign below_c = ram_rdata[ColW-1:0];

  // Width of the popped bar: up to the entry below it, or from column 0
  assign base  = flush_q ? (DepW'(c_q) + DepW'(1)) : DepW'(c_q);
  assign width = (depth_q == DepW'(1)) ? base : (base - DepW'(below_c) - DepW'(1));
  assign more  = (depth_q >= DepW'(2)) && (flush_q || (below_h > h_q));

  // Push, pop and flush sequencing
  always_comb begin
    state_d   = state_q;
    top_h_d   = top_h_q;
    top_c_d   = top_c_q;
    depth_d   = depth_q;
    h_d       = h_q;
    c_d       = c_q;
    last_d    = last_q;
    flush_d   = flush_q;
    ram_we    = 1'b0;
    ram_waddr = dm1[ColW-1:0];
    ram_wdata = {top_h_q, top_c_q};
    ram_raddr = dm2[ColW-1:0];
    mul_v_d   = 1'b0;
    mul_h     = top_h_q;
    mul_w     = width;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          h_d     = cmd_h_i;
          c_d     = cmd_col_i;
          last_d  = cmd_last_i;
          flush_d = 1'b0;
          if ((depth_q != '0) && (top_h_q > cmd_h_i)) begin
            state_d = S_POP;
          end else begin
            ram_we  = (depth_q != '0);
            top_h_d = cmd_h_i;
            top_c_d = cmd_col_i;
            depth_d = depth_q + DepW'(1);
            state_d = cmd_last_i ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_POP: begin
        mul_v_d = 1'b1;
        depth_d = dm1;
        if (depth_q >= DepW'(2)) begin
          top_h_d = below_h;
          top_c_d = below_c;
        end
        if (more) begin
          ram_raddr = dm3[ColW-1:0];
        end else if (flush_q) begin
          state_d = S_DRAIN;
        end else begin
          // Entry below stays in the RAM, new column becomes the top
          top_h_d = h_q;
          top_c_d = c_q;
          depth_d = depth_q;
          state_d = last_q ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        flush_d = 1'b1;
        state_d = S_POP;
      end
      S_DRAIN: begin
        state_d = S_HOLD;
      end
      S_HOLD: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Saturated score of the last product
  assign area = (CmpW'(mul_q) > CmpW'(AreaMax)) ? AreaMax : AreaW'(mul_q);

  always_comb begin
    best_d = best_q;
    if ((state_q == S_HOLD) && ack_i) begin
      best_d = '0;
    end else if (mul_v_q && (area > best_q)) begin
      best_d = area;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      flush_q <= 1'b0;
      last_q  <= 1'b0;
      mul_v_q <= 1'b0;
      best_q  <= '0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      flush_q <= flush_d;
      last_q  <= last_d;
      mul_v_q <= mul_v_d;
      best_q  <= best_d;
    end
  end

  // Payload registers and the multiplier stage
  always_ff @(posedge clk_i) begin
    top_h_q <= top_h_d;
    top_c_q <= top_c_d;
    h_q     <= h_d;
    c_q     <= c_d;
    mul_q   <= PW'(mul_h) * PW'(mul_w);
  end

  dhmr_ram #(
    .Width(EntW),
    .Depth(MaxColumns)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign status_o.idle = (state_q == S_IDLE);
  assign status_o.hold = (state_q == S_HOLD);
  assign status_o.best = best_q;

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (depth_q != '0))
    else $error("pop with empty stack");
  a_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD) |-> (depth_q == '0) && !mul_v_q)
    else $error("result held before stack flushed");
  a_depth_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepW'(MaxColumns))
    else $error("stack depth beyond capacity");
`endif

endmodule

FILE: dv/dhmr_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the block, predicts the best rectangle area of
// each query and compares every result against the oldest expectation.
module dhmr_checker #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_HEIGHT  = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [dhmr_pkg::HeightW-1:0]  height_first_i,
  input  logic [dhmr_pkg::HeightW-1:0]  height_second_i,
  input  logic                          last_column_i,
  input  logic                          valid_i,
  input  logic [dhmr_pkg::AreaW-1:0]    max_area_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import dhmr_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_COLUMNS);
  localparam int unsigned NumHist = 2;

  // Per-histogram monotonic stacks, bar heights by column, best area so far
  logic [ColW-1:0]    col_stack   [NumHist][MAX_COLUMNS];
  logic [HeightW-1:0] bar_height  [NumHist][MAX_COLUMNS];
  int unsigned        stack_depth [NumHist];
  logic [AreaW-1:0]   best_area   [NumHist];
  int unsigned        next_col;
  int unsigned        fails;

  // Areas expected on max_area, oldest first
  logic [AreaW-1:0]   area_q [$];

  function automatic logic [AreaW-1:0] rect_area(input int unsigned h, input int unsigned w);
    longint unsigned prod;
    prod = longint'(h) * longint'(w);
    if (prod > longint'(AreaMax)) return AreaMax;
    return prod[AreaW-1:0];
  endfunction

  task automatic score_rect(input int hi, input int unsigned h, input int unsigned w);
    logic [AreaW-1:0] a;
    a = rect_area(h, w);
    if (a > best_area[hi]) best_area[hi] = a;
  endtask

  // Pop every taller bar, scoring it, then push this column
  task automatic push_bar(input int hi, input int unsigned col, input logic [HeightW-1:0] h);
    logic [HeightW-1:0] top_h;
    int unsigned        w;
    bit                 done;
    bar_height[hi][col] = h;
    done = 1'b0;
    while (stack_depth[hi] > 0 && !done) begin
      top_h = bar_height[hi][col_stack[hi][stack_depth[hi]-1]];
      if (top_h <= h) begin
        done = 1'b1;
      end else begin
        stack_depth[hi]--;
        // an emptied stack means the bar reaches back to column 0
        if (stack_depth[hi] == 0) w = col;
        else w = col - col_stack[hi][stack_depth[hi]-1] - 1;
        score_rect(hi, top_h, w);
      end
    end
    if (stack_depth[hi] < MAX_COLUMNS) begin
      col_stack[hi][stack_depth[hi]] = col[ColW-1:0];
      stack_depth[hi]++;
    end
  endtask

  // Score everything left on the stack against the query length
  task automatic flush_bars(input int hi, input int unsigned count);
    logic [HeightW-1:0] top_h;
    int unsigned        w;
    while (stack_depth[hi] > 0) begin
      top_h = bar_height[hi][col_stack[hi][stack_depth[hi]-1]];
      stack_depth[hi]--;
      if (stack_depth[hi] == 0) w = count;
      else w = count - col_stack[hi][stack_depth[hi]-1] - 1;
      score_rect(hi, top_h, w);
    end
  endtask

  function automatic logic [HeightW-1:0] clamp_height(input logic [HeightW-1:0] h);
    return (h > MAX_HEIGHT) ? HeightW'(MAX_HEIGHT) : h;
  endfunction

  // One accepted column; queues an area when the query closes
  task automatic predict_column(input logic [HeightW-1:0] h1, input logic [HeightW-1:0] h2,
                                input logic last);
    int unsigned col;
    bit          closing;
    col     = next_col;
    closing = last;
    // the column at capacity closes the query on its own
    if (col >= MAX_COLUMNS - 1) begin
      col     = MAX_COLUMNS - 1;
      closing = 1'b1;
    end
    push_bar(0, col, clamp_height(h1));
    push_bar(1, col, clamp_height(h2));
    if (!closing) begin
      next_col = col + 1;
    end else begin
      flush_bars(0, col + 1);
      flush_bars(1, col + 1);
      area_q.push_back((best_area[0] > best_area[1]) ? best_area[0] : best_area[1]);
      for (int i = 0; i < NumHist; i++) begin
        stack_depth[i] = 0;
        best_area[i]   = '0;
      end
      next_col = 0;
    end
  endtask

  // Compare results first, then predict from the accepted column
  always @(posedge clk_i or negedge rst_ni) begin
    logic [AreaW-1:0] want;
    if (!rst_ni) begin
      for (int i = 0; i < NumHist; i++) begin
        stack_depth[i] = 0;
        best_area[i]   = '0;
      end
      next_col = 0;
      fails    = 0;
      area_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (valid_i) begin
        if (area_q.size() == 0) begin
          $error("unexpected result transaction: max_area actual %0d", max_area_i);
          fails++;
        end else begin
          want = area_q.pop_front();
          if (max_area_i !== want) begin
            $error("max_area mismatch: expected %0d, actual %0d", want, max_area_i);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_column(height_first_i, height_second_i, last_column_i);
      end
      fail_count_o <= fails;
      pending_o    <= area_q.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dhmr_pkg::*;

  localparam int unsigned MaxColumns  = 1024;
  localparam int unsigned MaxHeight   = 1024;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned PhaseCols   = 330;
  localparam int unsigned SettleCycles = 50;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [HeightW-1:0] height_first_i = '0;
  logic [HeightW-1:0] height_second_i = '0;
  logic               last_column_i = 1'b0;
  logic               valid_o;
  logic [AreaW-1:0]   max_area_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sender_idle_pct;
  int unsigned columns_sent;
  int unsigned stall_cycles;

  always #5 clk_i = ~clk_i;

  dual_histogram_max_rectangle #(
    .MAX_COLUMNS(MaxColumns),
    .MAX_HEIGHT (MaxHeight)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .height_first_i (height_first_i),
    .height_second_i(height_second_i),
    .last_column_i  (last_column_i),
    .valid_o        (valid_o),
    .max_area_o     (max_area_o)
  );

  dhmr_checker #(
    .MAX_COLUMNS(MaxColumns),
    .MAX_HEIGHT (MaxHeight)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .height_first_i (height_first_i),
    .height_second_i(height_second_i),
    .last_column_i  (last_column_i),
    .valid_i        (valid_o),
    .max_area_i     (max_area_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
          $display("tb: failure");
          $finish;
        end
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  // One column transaction; each cycle ahead of it idles with the set odds
  task automatic send_column(input logic [HeightW-1:0] h1, input logic [HeightW-1:0] h2,
                             input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    height_first_i  <= h1;
    height_second_i <= h2;
    last_column_i   <= last;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold off until every queued area has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [HeightW-1:0] random_height(input int unsigned mode);
    case (mode)
      0: return HeightW'($urandom_range(0, 2047));
      1: return HeightW'($urandom_range(0, 7));
      default: return HeightW'($urandom_range(1000, 1100));
    endcase
  endfunction

  // Mostly short queries, some medium, a few long ones
  task automatic random_query();
    int unsigned sel;
    int unsigned len;
    int unsigned mode;
    sel  = $urandom_range(99);
    len  = (sel < 70) ? $urandom_range(1, 16) :
           (sel < 95) ? $urandom_range(17, 64) : $urandom_range(65, 300);
    mode = $urandom_range(2);
    for (int unsigned c = 0; c < len; c++) begin
      send_column(random_height(mode), random_height(mode), c == len - 1);
    end
    columns_sent += len;
  endtask

  initial begin
    sender_idle_pct = 16;
    columns_sent    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-column queries: zero and clamped maximum height
    send_column(11'd0, 11'd0, 1'b1);
    send_column(11'h7FF, 11'd1, 1'b1);
    // Falling bars empty the stack mid-query; rising bars stay for the flush
    send_column(11'd5, 11'd1, 1'b0);
    send_column(11'd4, 11'd2, 1'b0);
    send_column(11'd3, 11'd3, 1'b0);
    send_column(11'd0, 11'd4, 1'b1);
    // Equal heights never pop; heights just over and at the maximum
    send_column(11'd7, 11'h555, 1'b0);
    send_column(11'd7, 11'h2AA, 1'b0);
    send_column(11'd7, 11'd1025, 1'b0);
    send_column(11'd7, 11'd1024, 1'b1);
    // Mixed bit patterns
    send_column(11'h2AA, 11'h555, 1'b0);
    send_column(11'h400, 11'h400, 1'b0);
    send_column(11'd1, 11'h7FE, 1'b0);
    send_column(11'd9, 11'd0, 1'b0);
    send_column(11'd9, 11'd0, 1'b1);
    drain();

    // Three traffic phases: light idling, heavy idling, none
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 68 : 0;
      columns_sent    = 0;
      if (phase == 2) begin
        // Full-capacity query with no last flag: closes at the last column,
        // keeps the stack full and reaches the largest area
        for (int unsigned c = 0; c < MaxColumns; c++) begin
          send_column(HeightW'($urandom_range(1024, 2047)),
                      HeightW'($urandom_range(1024, 2047)), 1'b0);
        end
      end
      while (columns_sent < PhaseCols) begin
        random_query();
        if ($urandom_range(19) == 0) drain();
      end
      drain();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/dhmr_pkg.sv
rtl/core/dhmr_ram.sv
rtl/core/dhmr_front.sv
rtl/core/dhmr_stack.sv
rtl/core/dual_histogram_max_rectangle.sv
dv/dhmr_checker.sv
dv/tb_top.sv
